// ----- src/triangle_face_normal_assert.svh -----
// Assertion macros for the triangle face normal checker.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TFN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define TFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tfn_pkg.sv -----
// Shared constants and types for the triangle face normal pipeline.
package tfn_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int OUT_W      = NORMAL_FRAC_BITS + 2;
    localparam int EDGE_W     = COORD_WIDTH + 1;
    localparam int PROD_W     = 2 * OUT_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int CROSS_W    = 2 * NORMAL_FRAC_BITS + 3;
    localparam int UIN_W      = (EDGE_W > CROSS_W) ? EDGE_W : CROSS_W;
    localparam int TOP_W      = $clog2(UIN_W);
    localparam int SCALE_TOP  = 29;
    localparam int NORM_W     = SCALE_TOP + 1;
    localparam int SQ_W       = 2 * NORM_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_K     = SUM_W / 2;
    localparam int ROOT_W     = ROOT_K;
    localparam int QUOT_W     = NORMAL_FRAC_BITS + 1;
    localparam int DIV_W      = ROOT_W + QUOT_W;
    localparam int UNIT_LAT   = ROOT_K + NORMAL_FRAC_BITS + 8;
    localparam int PIPE_LAT   = 2 * UNIT_LAT + 6;
    localparam int IN_DATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [UIN_W-1:0] x;
        logic signed [UIN_W-1:0] y;
        logic signed [UIN_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic                    nonzero;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } unit_t;

endpackage

// ----- src/tfn_unitize.sv -----
// Pipelined scaling of a three-component vector to unit length in Q1.F.
module tfn_unitize (
    input  logic          clk,
    input  logic          en,
    input  tfn_pkg::vec_t vec,
    output tfn_pkg::unit_t unit
);
    import tfn_pkg::*;

    logic signed [UIN_W-1:0] comp [3];
    assign comp[0] = vec.x;
    assign comp[1] = vec.y;
    assign comp[2] = vec.z;

    // Stage 1: sign and magnitude of each component.
    logic [UIN_W-1:0] mag1_next [3];
    logic [UIN_W-1:0] mag1_reg  [3];
    logic [2:0]       neg1_next, neg1_reg;
    logic [UIN_W-1:0] or1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_next[i] = comp[i][UIN_W-1];
            mag1_next[i] = neg1_next[i] ? UIN_W'(-comp[i]) : UIN_W'(comp[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
            or1_reg  <= mag1_next[0] | mag1_next[1] | mag1_next[2];
        end
    end

    // Stage 2: position of the leading one of the largest magnitude.
    logic [TOP_W-1:0] top2_next, top2_reg;
    logic [UIN_W-1:0] mag2_reg [3];
    logic [2:0]       neg2_reg;
    logic             zero2_reg;

    always_comb
    begin
        top2_next = '0;
        for (int b = 0; b < UIN_W; b++)
        begin
            if (or1_reg[b])
            begin
                top2_next = TOP_W'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top2_reg  <= top2_next;
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            zero2_reg <= (or1_reg == '0);
        end
    end

    // Stage 3: common shift that puts the leading one at the scale top.
    logic [NORM_W-1:0] mag3_next [3];
    logic [NORM_W-1:0] mag3_reg  [3];
    logic [2:0]        neg3_reg;
    logic              zero3_reg;

    always_comb
    begin
        logic [UIN_W+SCALE_TOP-1:0] wide;
        for (int i = 0; i < 3; i++)
        begin
            wide = (UIN_W+SCALE_TOP)'(mag2_reg[i]);
            if (int'(top2_reg) > SCALE_TOP)
            begin
                mag3_next[i] = NORM_W'(mag2_reg[i] >> (int'(top2_reg) - SCALE_TOP));
            end
            else
            begin
                mag3_next[i] = NORM_W'(wide << (SCALE_TOP - int'(top2_reg)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag3_reg  <= mag3_next;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // Stage 4: squares.
    logic [SQ_W-1:0]   sq4_reg  [3];
    logic [NORM_W-1:0] mag4_reg [3];
    logic [2:0]        neg4_reg;
    logic              zero4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq4_reg[i] <= mag3_reg[i] * mag3_reg[i];
            end
            mag4_reg  <= mag3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // Stage 5: sum of squares.
    logic [SUM_W-1:0]  sum5_reg;
    logic [NORM_W-1:0] mag5_reg [3];
    logic [2:0]        neg5_reg;
    logic              zero5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum5_reg  <= SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    // Square root, one result bit per stage.
    logic [SUM_W-1:0]  rx_reg   [ROOT_K];
    logic [SUM_W-1:0]  rr_reg   [ROOT_K];
    logic [NORM_W-1:0] rmag_reg [ROOT_K][3];
    logic [2:0]        rneg_reg [ROOT_K];
    logic              rzero_reg [ROOT_K];

    for (genvar k = 0; k < ROOT_K; k++)
    begin : g_root
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_K - 1 - k));
        logic [SUM_W-1:0]  x_in, r_in, x_next, r_next;
        logic [SUM_W:0]    trial;
        logic [NORM_W-1:0] mag_in [3];
        logic [2:0]        neg_in;
        logic              zero_in;

        if (k == 0)
        begin : g_first
            assign x_in    = sum5_reg;
            assign r_in    = '0;
            assign mag_in  = mag5_reg;
            assign neg_in  = neg5_reg;
            assign zero_in = zero5_reg;
        end
        else
        begin : g_next
            assign x_in    = rx_reg[k-1];
            assign r_in    = rr_reg[k-1];
            assign mag_in  = rmag_reg[k-1];
            assign neg_in  = rneg_reg[k-1];
            assign zero_in = rzero_reg[k-1];
        end

        always_comb
        begin
            trial = {1'b0, r_in} + {1'b0, BIT};
            if ({1'b0, x_in} >= trial)
            begin
                x_next = x_in - trial[SUM_W-1:0];
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k]    <= x_next;
                rr_reg[k]    <= r_next;
                rmag_reg[k]  <= mag_in;
                rneg_reg[k]  <= neg_in;
                rzero_reg[k] <= zero_in;
            end
        end
    end

    // Numerators with half the length added for round to nearest.
    logic [ROOT_W-1:0] len;
    logic [DIV_W-1:0]  num_reg [3];
    logic [ROOT_W-1:0] nlen_reg;
    logic [2:0]        nneg_reg;
    logic              nzero_reg;

    assign len = rr_reg[ROOT_K-1][ROOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= (DIV_W'(rmag_reg[ROOT_K-1][i]) << NORMAL_FRAC_BITS)
                              + DIV_W'(len >> 1);
            end
            nlen_reg  <= len;
            nneg_reg  <= rneg_reg[ROOT_K-1];
            nzero_reg <= rzero_reg[ROOT_K-1];
        end
    end

    // Restoring division, one quotient bit per stage.
    logic [DIV_W-1:0]  drem_reg [QUOT_W][3];
    logic [QUOT_W-1:0] dq_reg   [QUOT_W][3];
    logic [ROOT_W-1:0] dlen_reg [QUOT_W];
    logic [2:0]        dneg_reg [QUOT_W];
    logic              dzero_reg [QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_div
        localparam int SH = QUOT_W - 1 - j;
        logic [DIV_W-1:0]  rem_in  [3];
        logic [QUOT_W-1:0] q_in    [3];
        logic [DIV_W-1:0]  rem_next [3];
        logic [QUOT_W-1:0] q_next  [3];
        logic [DIV_W-1:0]  sub;
        logic [ROOT_W-1:0] len_in;
        logic [2:0]        neg_in;
        logic              zero_in;

        if (j == 0)
        begin : g_first
            assign rem_in  = num_reg;
            assign q_in    = '{default: '0};
            assign len_in  = nlen_reg;
            assign neg_in  = nneg_reg;
            assign zero_in = nzero_reg;
        end
        else
        begin : g_next
            assign rem_in  = drem_reg[j-1];
            assign q_in    = dq_reg[j-1];
            assign len_in  = dlen_reg[j-1];
            assign neg_in  = dneg_reg[j-1];
            assign zero_in = dzero_reg[j-1];
        end

        always_comb
        begin
            sub = DIV_W'(len_in) << SH;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= sub)
                begin
                    rem_next[i] = rem_in[i] - sub;
                    q_next[i]   = q_in[i] | (QUOT_W'(1) << SH);
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = q_in[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[j]  <= rem_next;
                dq_reg[j]    <= q_next;
                dlen_reg[j]  <= len_in;
                dneg_reg[j]  <= neg_in;
                dzero_reg[j] <= zero_in;
            end
        end
    end

    // Output: apply signs; a zero vector gives zeros.
    logic signed [OUT_W-1:0] comp_next [3];
    tfn_pkg::unit_t          unit_next, unit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dzero_reg[QUOT_W-1])
            begin
                comp_next[i] = '0;
            end
            else if (dneg_reg[QUOT_W-1][i])
            begin
                comp_next[i] = -$signed(OUT_W'(dq_reg[QUOT_W-1][i]));
            end
            else
            begin
                comp_next[i] = $signed(OUT_W'(dq_reg[QUOT_W-1][i]));
            end
        end
        unit_next.nonzero = !dzero_reg[QUOT_W-1];
        unit_next.x       = comp_next[0];
        unit_next.y       = comp_next[1];
        unit_next.z       = comp_next[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
        end
    end

    assign unit = unit_reg;

endmodule

// ----- src/triangle_face_normal.sv -----
// Top level of the triangle face normal pipeline.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+----------------------------------------
//  s_*     | in        | s_tvalid / s_tready | s_tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z
//  m_*     | out       | m_tvalid / m_tready | m_tdata: norm_x norm_y norm_z; m_tuser
//
// One triangle can enter every cycle while the pipeline is not held. Most of the
// pipeline lies in the two unit-length scalers in series;
// each scaler spends one stage per square-root bit and one per quotient bit.
// Reset clears only the valid bits; payload registers are left as they are.
// The whole pipeline holds while a finished result waits on m_tready; it keeps
// moving whenever the output stage is empty or being taken.
module triangle_face_normal (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, each COORD_WIDTH bits, from bit 0.
    input  logic [tfn_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // norm_x, norm_y, norm_z, each OUT_W bits, from bit 0, zero filled to bytes.
    output logic [tfn_pkg::OUT_DATA_W-1:0]   m_tdata,
    // degenerate (bit 0).
    output logic                             m_tuser
);
    import tfn_pkg::*;

    // The pipeline advances when the output stage is free or being read.
    logic en;
    logic s_accept;
    logic [PIPE_LAT-1:0] valid_reg;

    assign en       = !valid_reg[PIPE_LAT-1] || m_tready;
    assign s_tready = en;
    assign s_accept = s_tvalid && en;
    assign m_tvalid = valid_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], s_accept};
        end
    end

    // Corner coordinates unpacked from the input item.
    logic signed [COORD_WIDTH-1:0] corner [3][3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                corner[k][i] = s_tdata[(3*k+i)*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    // Edge vectors B-A, C-B and A-C.
    logic signed [EDGE_W-1:0] edge_reg [3][3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                edge_reg[0][i] <= EDGE_W'(corner[1][i]) - EDGE_W'(corner[0][i]);
                edge_reg[1][i] <= EDGE_W'(corner[2][i]) - EDGE_W'(corner[1][i]);
                edge_reg[2][i] <= EDGE_W'(corner[0][i]) - EDGE_W'(corner[2][i]);
            end
        end
    end

    // Each edge is scaled to unit length in its own scaler.
    vec_t  edge_vec [3];
    unit_t edge_unit [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_edge
        assign edge_vec[k].x = UIN_W'(edge_reg[k][0]);
        assign edge_vec[k].y = UIN_W'(edge_reg[k][1]);
        assign edge_vec[k].z = UIN_W'(edge_reg[k][2]);

        tfn_unitize u_edge_unit (
            .clk  (clk),
            .en   (en),
            .vec  (edge_vec[k]),
            .unit (edge_unit[k])
        );
    end

    logic signed [OUT_W-1:0] u [3][3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u[k][0] = edge_unit[k].x;
            u[k][1] = edge_unit[k].y;
            u[k][2] = edge_unit[k].z;
        end
    end

    // Stage 1 after the scalers: products for the three dot products.
    logic signed [PROD_W-1:0] dp1_reg [3][3];
    logic signed [OUT_W-1:0]  u1_reg  [3][3];
    logic                     ok1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp1_reg[0][i] <= u[0][i] * u[1][i];
                dp1_reg[1][i] <= u[1][i] * u[2][i];
                dp1_reg[2][i] <= u[2][i] * u[0][i];
            end
            u1_reg  <= u;
            ok1_reg <= edge_unit[0].nonzero && edge_unit[1].nonzero && edge_unit[2].nonzero;
        end
    end

    // Stage 2: absolute dot products.
    logic signed [DOT_W-1:0] dsum;
    logic [DOT_W-1:0]        dabs_next [3];
    logic [DOT_W-1:0]        dabs2_reg [3];
    logic signed [OUT_W-1:0] u2_reg [3][3];
    logic                    ok2_reg;

    always_comb
    begin
        dsum = '0;
        for (int d = 0; d < 3; d++)
        begin
            dsum = DOT_W'(dp1_reg[d][0]) + DOT_W'(dp1_reg[d][1]) + DOT_W'(dp1_reg[d][2]);
            dabs_next[d] = dsum[DOT_W-1] ? DOT_W'(-dsum) : DOT_W'(dsum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dabs2_reg <= dabs_next;
            u2_reg    <= u1_reg;
            ok2_reg   <= ok1_reg;
        end
    end

    // Stage 3: pick the pair of edges closest to perpendicular.
    // A tie with the third and first edges goes to that pair; a tie of the other two goes to the second and third.
    logic [1:0]              sel_a, sel_b;
    logic signed [OUT_W-1:0] pa3_reg [3];
    logic signed [OUT_W-1:0] pb3_reg [3];
    logic                    ok3_reg;

    always_comb
    begin
        if (dabs2_reg[0] < dabs2_reg[1])
        begin
            if (dabs2_reg[0] < dabs2_reg[2])
            begin
                sel_a = 2'd0;
                sel_b = 2'd1;
            end
            else
            begin
                sel_a = 2'd2;
                sel_b = 2'd0;
            end
        end
        else if (dabs2_reg[1] < dabs2_reg[2])
        begin
            sel_a = 2'd1;
            sel_b = 2'd2;
        end
        else
        begin
            sel_a = 2'd2;
            sel_b = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                case (sel_a)
                    2'd0:    pa3_reg[i] <= u2_reg[0][i];
                    2'd1:    pa3_reg[i] <= u2_reg[1][i];
                    default: pa3_reg[i] <= u2_reg[2][i];
                endcase
                case (sel_b)
                    2'd0:    pb3_reg[i] <= u2_reg[0][i];
                    2'd1:    pb3_reg[i] <= u2_reg[1][i];
                    default: pb3_reg[i] <= u2_reg[2][i];
                endcase
            end
            ok3_reg <= ok2_reg;
        end
    end

    // Stage 4: the six products of the cross product.
    logic signed [PROD_W-1:0] cp4_reg [6];
    logic                     ok4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp4_reg[0] <= pa3_reg[1] * pb3_reg[2];
            cp4_reg[1] <= pa3_reg[2] * pb3_reg[1];
            cp4_reg[2] <= pa3_reg[2] * pb3_reg[0];
            cp4_reg[3] <= pa3_reg[0] * pb3_reg[2];
            cp4_reg[4] <= pa3_reg[0] * pb3_reg[1];
            cp4_reg[5] <= pa3_reg[1] * pb3_reg[0];
            ok4_reg    <= ok3_reg;
        end
    end

    // Stage 5: cross product; a zero edge forces a zero vector so that the
    // final scaler flags the triangle as degenerate.
    logic signed [PROD_W:0] cdiff [3];
    vec_t                   cross_next, cross5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cdiff[i] = (PROD_W+1)'(cp4_reg[2*i]) - (PROD_W+1)'(cp4_reg[2*i+1]);
        end
        if (ok4_reg)
        begin
            cross_next.x = UIN_W'($signed(CROSS_W'(cdiff[0])));
            cross_next.y = UIN_W'($signed(CROSS_W'(cdiff[1])));
            cross_next.z = UIN_W'($signed(CROSS_W'(cdiff[2])));
        end
        else
        begin
            cross_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cross5_reg <= cross_next;
        end
    end

    // Final scaling of the cross product gives the face normal.
    unit_t normal;

    tfn_unitize u_normal_unit (
        .clk  (clk),
        .en   (en),
        .vec  (cross5_reg),
        .unit (normal)
    );

    assign m_tdata = OUT_DATA_W'({normal.z, normal.y, normal.x});
    assign m_tuser = !normal.nonzero;

endmodule

// ----- src/tfn_checker.sv -----
// Port-level checker for the triangle face normal block, with its bind.
module tfn_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tfn_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import tfn_pkg::*;

`include "triangle_face_normal_assert.svh"

    localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << NORMAL_FRAC_BITS;

    logic signed [OUT_W-1:0] nx, ny, nz;
    logic                    in_range;
    logic                    s_seen;

    assign nx = m_tdata[OUT_W-1:0];
    assign ny = m_tdata[2*OUT_W-1:OUT_W];
    assign nz = m_tdata[3*OUT_W-1:2*OUT_W];
    assign in_range = (nx <= ONE) && (nx >= -ONE) && (ny <= ONE) && (ny >= -ONE)
                      && (nz <= ONE) && (nz >= -ONE);
    assign s_seen = s_tvalid || !s_tvalid;

    // A waiting result must hold still until it is taken.
    `TFN_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The input side is open exactly when the output stage can move.
    `TFN_ASSERT_ALWAYS(a_ready_follows_out, clk, s_seen |-> s_tready == (!m_tvalid || m_tready), "input ready does not follow output stage")

    // A degenerate triangle carries a zero normal.
    `TFN_ASSERT_ALWAYS(a_degen_zero, clk, m_tvalid && m_tuser |-> m_tdata == '0, "degenerate result with nonzero normal")

    // Every normal component stays within one unit.
    `TFN_ASSERT_ALWAYS(a_unit_range, clk, m_tvalid && !m_tuser |-> in_range, "normal component beyond unit length")

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
